FILE: hw/rtl/srtf_pkg.sv
// shared types and constants for the srtf task scheduler
`timescale 1ns / 1ps

package srtf_pkg;

  localparam int ID_W   = 8;
  localparam int TIME_W = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // input beat kinds carried on tuser
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // tdata widths of both channels
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 64;

  // one slot table entry as stored in the ram
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] arrival;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // one result beat, lowest field last in the struct
  typedef struct packed {
    logic [M_DATA_W-60:0] pad;
    logic [TIME_W-1:0]    waiting_time;
    logic [TIME_W-1:0]    turnaround;
    logic [TIME_W-1:0]    finish_time;
    logic                 finished;
    logic [ID_W-1:0]      running_id;
    logic                 busy_res;
    logic                 accepted;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/srtf_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/srtf_ctrl.sv
// controller state machine of the srtf task scheduler
`timescale 1ns / 1ps

module srtf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srtf_pkg::dp_status_t sts,
  output srtf_pkg::ctrl_cmd_t  ctl
);
  import srtf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    ctl.start  = (state == ST_IDLE) && in_valid;
    ctl.issue  = (state == ST_SCAN);
    ctl.commit = (state == ST_EXEC) && sts.out_free;
  end

endmodule

FILE: hw/rtl/srtf_dp.sv
// datapath of the srtf task scheduler: slot table, scan, update and result register
`timescale 1ns / 1ps

module srtf_dp #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srtf_pkg::ctrl_cmd_t           ctl,
  output srtf_pkg::dp_status_t          sts,
  input  logic                          in_cmd,
  input  logic [srtf_pkg::ID_W-1:0]     in_id,
  input  logic [srtf_pkg::TIME_W-1:0]   in_burst,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srtf_pkg::M_DATA_W-1:0] out_data
);
  import srtf_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  // latched input beat
  logic              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] burst_q;

  logic [SLOTS-1:0]  valid;
  logic [TIME_W-1:0] now_time;

  // scan pipeline
  logic [IDX_W-1:0]  addr;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_pend;
  slot_entry_t       rd_entry;
  logic [ENTRY_W-1:0] rd_raw;
  logic              rd_valid;

  // scan findings
  logic              dup;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  slot_entry_t       best;

  // commit side
  logic              we;
  logic [IDX_W-1:0]  waddr;
  slot_entry_t       wentry;
  logic              arr_ok;
  logic [TIME_W-1:0] now_next;
  logic [TIME_W-1:0] rem_dec;
  logic [TIME_W-1:0] tat;
  result_t           res;

  assign rd_entry = slot_entry_t'(rd_raw);
  assign rd_valid = valid[rd_idx];

  srtf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (addr),
    .rdata (rd_raw)
  );

  assign sts.scan_last = (addr == IDX_W'(SLOTS - 1));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_q   <= in_cmd;
      id_q    <= in_id;
      burst_q <= in_burst;
    end
    if (ctl.issue) begin
      rd_idx <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr    <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= ctl.issue;
      if (ctl.start) begin
        addr <= '0;
      end else if (ctl.issue && !sts.scan_last) begin
        addr <= addr + IDX_W'(1);
      end
    end
  end

  // compare each slot as its read data comes back
  always_ff @(posedge clk) begin
    if (rst) begin
      dup        <= 1'b0;
      free_found <= 1'b0;
      found      <= 1'b0;
    end else if (ctl.start) begin
      dup        <= 1'b0;
      free_found <= 1'b0;
      found      <= 1'b0;
    end else if (rd_pend) begin
      if (rd_valid && rd_entry.id == id_q) begin
        dup <= 1'b1;
      end
      if (!rd_valid && !free_found) begin
        free_found <= 1'b1;
      end
      if (rd_valid && (!found || rd_entry.remaining < best.remaining)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      if (!rd_valid && !free_found) begin
        free_idx <= rd_idx;
      end
      if (rd_valid && (!found || rd_entry.remaining < best.remaining)) begin
        best_idx <= rd_idx;
        best     <= rd_entry;
      end
    end
  end

  always_comb begin
    arr_ok   = (burst_q != '0) && !dup && free_found;
    now_next = (now_time == TIME_MAX) ? now_time : now_time + TIME_W'(1);
    rem_dec  = best.remaining - TIME_W'(1);
    tat      = now_next - best.arrival;

    we     = 1'b0;
    waddr  = free_idx;
    wentry = '{id: id_q, remaining: burst_q, burst: burst_q, arrival: now_time};
    res    = '0;

    if (cmd_q == CMD_ARRIVE) begin
      we           = ctl.commit && arr_ok;
      res.accepted = arr_ok;
    end else begin
      we             = ctl.commit && found;
      waddr          = best_idx;
      wentry         = best;
      wentry.remaining = rem_dec;
      res.busy_res   = found;
      if (found) begin
        res.running_id = best.id;
        if (rem_dec == '0) begin
          res.finished     = 1'b1;
          res.finish_time  = now_next;
          res.turnaround   = tat;
          res.waiting_time = (tat >= best.burst) ? tat - best.burst : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      now_time <= '0;
    end else if (ctl.commit) begin
      if (cmd_q == CMD_ARRIVE) begin
        if (arr_ok) valid[free_idx] <= 1'b1;
      end else begin
        now_time <= now_next;
        if (found && rem_dec == '0) valid[best_idx] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_data <= res;
    end
  end

endmodule

FILE: hw/rtl/srtf_task_scheduler.sv
// top level of the preemptive shortest-remaining-time-first task scheduler
`timescale 1ns / 1ps

// Preemptive shortest-remaining-time-first scheduler over a table of SLOTS task slots.
// Every input beat gives exactly one result beat. An arrive beat (tuser = 0) enters a
// task id and burst stamped with the current clock; it is rejected when the burst is
// zero, the id is already present or the table is full, and otherwise takes the lowest
// free slot. A tick beat (tuser = 1) runs the valid task with the least remaining time
// (lowest slot on ties) for one unit, advances the clock (saturating at 65535) and, when
// that task completes, frees its slot and reports finish time, turnaround and waiting
// time. The scan reads one slot per cycle from the single slot table ram. A result waits
// in an output register, so the next beat is taken while it is still pending; a new result
// holds off only while that register stays stalled. Slot valid bits live in flops and
// clear at reset, so no clearing pass is needed.
module srtf_task_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input beats
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [srtf_pkg::S_DATA_W-1:0] s_axis_tdata,  // task_id[7:0], burst[23:8]
  input  logic [0:0]                    s_axis_tuser,  // cmd[0]
  // result beats
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // accepted[0], busy_res[1], running_id[9:2], finished[10], finish_time[26:11],
  // turnaround[42:27], waiting_time[58:43], zero[63:59]
  output logic [srtf_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import srtf_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  // sequencing: accept, scan, compare tail, commit
  srtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // slot table, min and id scan, update and result register
  srtf_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_cmd    (s_axis_tuser[0]),
    .in_id     (s_axis_tdata[ID_W-1:0]),
    .in_burst  (s_axis_tdata[ID_W+TIME_W-1:ID_W]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: hw/rtl/srtf_checker.sv
// port level checks of the srtf task scheduler and their binding
`timescale 1ns / 1ps

module srtf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // an arrive result never reports a run
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("accepted and busy_res both set");

  // completion only for a task that ran
  a_fin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[1])
    else $error("finished without a running task");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[63:59] == 5'd0)
    else $error("nonzero padding in result beat");

endmodule

bind srtf_task_scheduler srtf_checker u_chk (.*);

FILE: tb/srtf_task_scheduler_test.sv
// self-checking testbench for the srtf task scheduler: directed, random and back to back runs
`timescale 1ns / 1ps

module srtf_task_scheduler_test;
  import srtf_pkg::*;

  localparam int SLOTS           = 16;
  localparam int WATCHDOG_CYCLES = 1000;
  localparam int RANDOM_ITEMS    = 520;
  localparam int TAIL_ITEMS      = 24;

  // shadow copy of the task table; works out the result beat of every accepted item
  class task_table_tracker;
    bit              slot_used [SLOTS];
    logic [7:0]      slot_tag  [SLOTS];
    logic [15:0]     slot_left [SLOTS];
    logic [15:0]     slot_need [SLOTS];
    logic [15:0]     slot_stamp[SLOTS];
    logic [15:0]     clock_now;
    int              occupied;
    result_t         due_results[$];
    int              errors;
    int              n_arrive, n_refused, n_tick, n_idle_tick, n_done;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      clock_now = '0;
      occupied  = 0;
      errors    = 0;
      n_arrive = 0; n_refused = 0; n_tick = 0; n_idle_tick = 0; n_done = 0;
    endfunction

    function void note_item(logic cmd, logic [7:0] id, logic [15:0] burst);
      result_t    r;
      int         free_at;
      int         pick;
      bit         dup;
      logic [15:0] tat;
      r       = '0;
      free_at = -1;
      pick    = -1;
      dup     = 1'b0;
      if (cmd == CMD_ARRIVE) begin
        n_arrive++;
        if (burst != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
              if (slot_tag[i] == id) dup = 1'b1;
            end else if (free_at < 0) begin
              free_at = i;
            end
          end
          // lowest free slot takes the task
          if (!dup && free_at >= 0) begin
            slot_tag[free_at]   = id;
            slot_left[free_at]  = burst;
            slot_need[free_at]  = burst;
            slot_stamp[free_at] = clock_now;
            slot_used[free_at]  = 1'b1;
            occupied++;
            r.accepted = 1'b1;
          end
        end
        if (!r.accepted) n_refused++;
      end else begin
        n_tick++;
        // least remaining wins, strict compare keeps the lowest slot on ties
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && (pick < 0 || slot_left[i] < slot_left[pick])) pick = i;
        end
        if (clock_now != TIME_MAX) clock_now++;
        if (pick < 0) begin
          n_idle_tick++;
        end else begin
          r.busy_res   = 1'b1;
          r.running_id = slot_tag[pick];
          slot_left[pick]--;
          if (slot_left[pick] == '0) begin
            tat             = clock_now - slot_stamp[pick];
            slot_used[pick] = 1'b0;
            occupied--;
            n_done++;
            r.finished     = 1'b1;
            r.finish_time  = clock_now;
            r.turnaround   = tat;
            // a saturated clock can leave turnaround below the burst
            r.waiting_time = (tat >= slot_need[pick]) ? tat - slot_need[pick] : '0;
          end
        end
      end
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [M_DATA_W-1:0] beat);
      result_t got;
      result_t want;
      got = result_t'(beat);
      if (due_results.size() == 0) begin
        $error("result beat %h arrived with no item outstanding", beat);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("accepted",     16'(want.accepted),   16'(got.accepted));
      compare_field("busy_res",     16'(want.busy_res),   16'(got.busy_res));
      compare_field("running_id",   16'(want.running_id), 16'(got.running_id));
      compare_field("finished",     16'(want.finished),   16'(got.finished));
      compare_field("finish_time",  want.finish_time,     got.finish_time);
      compare_field("turnaround",   want.turnaround,      got.turnaround);
      compare_field("waiting_time", want.waiting_time,    got.waiting_time);
      compare_field("zero pad",     16'(want.pad),        16'(got.pad));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  task_table_tracker tracker;
  bit                calm_tail = 1'b0;  // no idling on either side once set
  int                quiet_cycles = 0;

  always #10 clk = ~clk;

  srtf_task_scheduler #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // one input beat, with an optional random gap ahead of it
  task automatic push_item(input logic cmd, input logic [7:0] id, input logic [15:0] burst);
    int gap;
    gap = (!calm_tail && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 15)) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {burst, id};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.note_item(cmd, id, burst);
  endtask

  task automatic push_tick();
    push_item(CMD_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  // result side backpressure in bursts
  initial begin
    @(negedge rst);
    forever begin
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // result checking and the no-progress watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("srtf_task_scheduler_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int          arrive_pct;
    int          roll;
    logic [7:0]  id;
    logic [15:0] burst;
    tracker   = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle tick, zero burst, id and burst extremes, duplicate, fill, ties
    push_tick();
    push_item(CMD_ARRIVE, 8'd0,   16'd0);
    push_item(CMD_ARRIVE, 8'd255, 16'hFFFF);
    push_item(CMD_ARRIVE, 8'd255, 16'd3);
    push_item(CMD_ARRIVE, 8'd0,   16'd1);
    push_tick();
    for (int i = 1; i < SLOTS; i++) push_item(CMD_ARRIVE, 8'(i), 16'd2);
    push_item(CMD_ARRIVE, 8'd16, 16'd1);
    push_tick();
    push_tick();

    // random: arrivals from a small id pool so duplicates and a full table recur
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      arrive_pct = (tracker.occupied < 4) ? 65 : (tracker.occupied < 12) ? 45 : 25;
      if ($urandom_range(0, 99) < arrive_pct) begin
        id    = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 23))
                                           : 8'($urandom_range(0, 255));
        roll  = $urandom_range(0, 99);
        burst = (roll < 3) ? 16'd0 : (roll < 90) ? 16'($urandom_range(1, 12))
                                                  : 16'($urandom_range(13, 60));
        push_item(CMD_ARRIVE, id, burst);
      end else begin
        push_tick();
      end
    end

    // back to back tail with no idling: a late short task, then ticks
    calm_tail = 1'b1;
    push_item(CMD_ARRIVE, 8'd77, 16'd3);
    for (int n = 0; n < TAIL_ITEMS; n++) push_tick();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d arrivals (%0d refused) and %0d ticks (%0d idle)",
             tracker.n_arrive, tracker.n_refused, tracker.n_tick, tracker.n_idle_tick);
    $display("%0d tasks completed, clock ended at %0d", tracker.n_done, tracker.clock_now);
    if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
      $display("srtf_task_scheduler_test OK");
    end else begin
      $display("srtf_task_scheduler_test NOT OK");
    end
    $finish;
  end

endmodule
